/* src/yolo_detection_decode_filter_assert.svh */
// Assertion macros for the YOLO decode filter.
// Depends on signals named clk and rst_n in the module that expands them.
`ifndef YOLO_DETECTION_DECODE_FILTER_ASSERT_SVH
`define YOLO_DETECTION_DECODE_FILTER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define YDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define YDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ydf_pkg.sv */
// Shared types, constants and functions of the YOLO decode filter.
// No dependencies; every other file but the assertion header uses this package.
package ydf_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SER_TERMS   = 24;
  localparam int DIV_N_W     = 53;
  localparam int DIV_D_W     = 34;

  typedef logic signed [15:0] logit_t;

  typedef enum logic [2:0] {
    REG_SCALE   = 3'd0,
    REG_GRID_W  = 3'd1,
    REG_GRID_H  = 3'd2,
    REG_CLASSES = 3'd3,
    REG_CONF    = 3'd4
  } cfg_reg_t;

  // One finished detection, handed from the front to the back.
  typedef struct packed {
    logit_t [3:0] box;
    logit_t       obj;
    logit_t       best;
    logic [6:0]   best_idx;
    logic [7:0]   col;
    logic [7:0]   row;
    logic [1:0]   slot;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  function automatic logic [8:0] anchor_wd(input logic [1:0] sel, input logic [1:0] slot);
    logic [8:0] r;
    case ({sel, slot})
      4'h0:    r = 9'd10;
      4'h1:    r = 9'd16;
      4'h2:    r = 9'd33;
      4'h4:    r = 9'd30;
      4'h5:    r = 9'd62;
      4'h6:    r = 9'd59;
      4'h8:    r = 9'd116;
      4'h9:    r = 9'd156;
      4'hA:    r = 9'd373;
      default: r = 9'd373;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] anchor_ht(input logic [1:0] sel, input logic [1:0] slot);
    logic [8:0] r;
    case ({sel, slot})
      4'h0:    r = 9'd13;
      4'h1:    r = 9'd30;
      4'h2:    r = 9'd23;
      4'h4:    r = 9'd61;
      4'h5:    r = 9'd45;
      4'h6:    r = 9'd119;
      4'h8:    r = 9'd90;
      4'h9:    r = 9'd198;
      4'hA:    r = 9'd326;
      default: r = 9'd326;
    endcase
    return r;
  endfunction

  // Q32 pixel value to Q12.4, rounded half up, clamped to 0..65535.
  function automatic logic [15:0] to_q4(input logic signed [49:0] v);
    logic [49:0] r;
    logic [15:0] o;
    r = 50'(v + 50'sd134217728) >> 28;
    if (v <= 50'sd0) o = 16'd0;
    else if (r > 50'd65535) o = 16'hFFFF;
    else o = r[15:0];
    return o;
  endfunction

endpackage

/* src/ydf_ifs.sv */
// Valid/ready channel interfaces of the YOLO decode filter.
// Depends on ydf_pkg.
interface ydf_in_if;
  logic                 valid;
  logic                 ready;
  ydf_pkg::logit_t      logit;
  logic                 frame_start;
  modport source(output valid, logit, frame_start, input ready);
  modport sink(input valid, logit, frame_start, output ready);
endinterface

interface ydf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] x_min;
  logic [15:0] y_min;
  logic [15:0] x_max;
  logic [15:0] y_max;
  logic [15:0] score;
  logic [6:0]  class_index;
  modport source(output valid, x_min, y_min, x_max, y_max, score, class_index, input ready);
  modport sink(input valid, x_min, y_min, x_max, y_max, score, class_index, output ready);
endinterface

/* src/yolo_detection_decode_filter.sv */
// Top level of the YOLOv5 anchor-box decode and confidence filter.
// Depends on ydf_pkg, ydf_ifs, ydf_front, ydf_queue, ydf_back and the assert header.
//
//  channel | dir | handshake        | word
//  in_ch   | in  | valid/ready      | logit (Q8.8 signed), frame_start
//  out_ch  | out | valid/ready      | x_min, y_min, x_max, y_max, score, class_index
//  cfg_*   | in  | cfg_we, no ready | cfg_index, cfg_data
//
// The front takes one logit word per cycle while the job queue has room.
// Each detection that reaches its last class logit costs the back six sigmoids
// if it passes and two if it is dropped; series terms and divider bits dominate
// the cost of each sigmoid.
// Reset is synchronous, active low; it clears counters, queue and FSMs.
// A full queue holds in_ch.ready low; a held output word stalls the back, which can then fill the queue.
module yolo_detection_decode_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  ydf_in_if.sink                          in_ch,
  ydf_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ydf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ydf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ydf_pkg::*;
  `include "yolo_detection_decode_filter_assert.svh"

  logic [1:0]  scale_r;
  logic [7:0]  grid_w_r;
  logic [7:0]  grid_h_r;
  logic [7:0]  classes_r;
  logic [15:0] conf_r;
  logic [1:0]  sel;

  logic        q_push;
  logic        q_pop;
  job_t        q_in;
  job_t        q_out;
  q_stat_t     q_stat;
  back_stat_t  b_stat;

  // Scale level three behaves as level two.
  assign sel = (scale_r == 2'd3) ? 2'd2 : scale_r;

  // Register file; writes beyond the list drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 2'd0;
      grid_w_r  <= 8'd80;
      grid_h_r  <= 8'd80;
      classes_r <= 8'd80;
      conf_r    <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:   scale_r   <= cfg_data[1:0];
        REG_GRID_W:  grid_w_r  <= cfg_data[7:0];
        REG_GRID_H:  grid_h_r  <= cfg_data[7:0];
        REG_CLASSES: classes_r <= cfg_data[7:0];
        REG_CONF:    conf_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  ydf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .grid_cols   (grid_w_r),
    .grid_rows   (grid_h_r),
    .class_count (classes_r),
    .q_stat      (q_stat),
    .push        (q_push),
    .job         (q_in)
  );

  ydf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (q_in),
    .pop     (q_pop),
    .job_out (q_out),
    .stat    (q_stat)
  );

  ydf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_stat.empty),
    .job        (q_out),
    .pop        (q_pop),
    .sel        (sel),
    .conf_level (conf_r),
    .out_ch     (out_ch),
    .stat       (b_stat)
  );

  `YDF_ASSERT_IMP(a_no_overflow, q_push, !q_stat.full, "job pushed into full queue")
  `YDF_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty, "job popped from empty queue")
  `YDF_ASSERT_NXT(a_push_lands, q_push, !q_stat.empty, "pushed job missing from queue")
  `YDF_ASSERT_IMP(a_out_from_back, $rose(out_ch.valid), $past(b_stat.busy), "result without decode")
endmodule

/* src/ydf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on ydf_pkg.
module ydf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ydf_pkg::DIV_N_W-1:0] dividend,
  input  logic [ydf_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [ydf_pkg::DIV_N_W-1:0] quotient
);
  import ydf_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [5:0]          cnt_r;
  logic [DIV_D_W-1:0]  rem_r;
  logic [DIV_D_W-1:0]  dvs_r;
  logic [DIV_N_W-1:0]  quo_r;
  logic [DIV_D_W:0]    shifted;
  logic                take;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_N_W-1]};
    take    = shifted >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'(DIV_N_W - 1);
      rem_r  <= '0;
      dvs_r  <= divisor;
      quo_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? DIV_D_W'(shifted - {1'b0, dvs_r}) : shifted[DIV_D_W-1:0];
      quo_r <= {quo_r[DIV_N_W-2:0], take};
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

/* src/ydf_sig.sv */
// Logistic unit: exp by a 24-term series and repeated multiplication by e^-1, then a divide.
// Depends on ydf_pkg and ydf_div.
module ydf_sig (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ydf_pkg::logit_t logit,
  output logic            done,
  output logic [15:0]     result
);
  import ydf_pkg::*;

  typedef enum logic [3:0] {
    SG_IDLE, SG_SER_MUL, SG_DIV_GO, SG_DIV_WAIT, SG_SER_ACC,
    SG_POW_MUL, SG_POW_ADD, SG_FIN_GO, SG_FIN_WAIT
  } sg_state_t;

  localparam logic [52:0] Q52_ONE = 53'h10_0000_0000_0000;

  sg_state_t          state_r;
  logic               neg_r;
  logic               phase_r;
  logic [15:0]        t_r;
  logic [52:0]        term_r;
  logic [52:0]        sum_r;
  logic [52:0]        prod_r;
  logic [4:0]         n_r;
  logic [7:0]         k_r;
  logic [32:0]        e_r;
  logic [32:0]        e1_r;
  logic [63:0]        mul_r;
  logic [15:0]        res_r;
  logic               done_r;

  logic [8:0]         fr;
  logic [61:0]        ser_prod;
  logic [52:0]        sum_new;
  logic [32:0]        e_val;
  logic [64:0]        pow_full;
  logic [33:0]        dnm;
  logic [DIV_N_W-1:0] num;
  logic               div_start;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic               div_done;
  logic [DIV_N_W-1:0] div_q;

  always_comb begin
    fr        = phase_r ? {1'b0, t_r[7:0]} : 9'd256;
    ser_prod  = term_r * fr;
    sum_new   = n_r[0] ? sum_r - term_r : sum_r + term_r;
    e_val     = 33'((sum_new + 53'd524288) >> 20);
    pow_full  = {1'b0, mul_r} + (e_r[32] ? {1'b0, e1_r[31:0], 32'd0} : 65'd0)
              + 65'h8000_0000;
    dnm       = 34'h1_0000_0000 + {1'b0, e_r};
    num       = neg_r ? DIV_N_W'({e_r, 16'd0}) + DIV_N_W'(dnm >> 1)
                      : DIV_N_W'(53'h1_0000_0000_0000) + DIV_N_W'(dnm >> 1);
    div_start    = (state_r == SG_DIV_GO) || (state_r == SG_FIN_GO);
    div_dividend = (state_r == SG_FIN_GO) ? num : prod_r;
    div_divisor  = (state_r == SG_FIN_GO) ? dnm : DIV_D_W'(n_r);
  end

  ydf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      state_r <= SG_IDLE;
    end else begin
      case (state_r)
        SG_IDLE: begin
          if (start) begin
            neg_r   <= logit[15];
            t_r     <= logit[15] ? 16'(-logit) : 16'(logit);
            phase_r <= 1'b0;
            term_r  <= Q52_ONE;
            sum_r   <= Q52_ONE;
            n_r     <= 5'd1;
            state_r <= SG_SER_MUL;
          end
        end
        SG_SER_MUL: begin
          prod_r  <= ser_prod[60:8];
          state_r <= SG_DIV_GO;
        end
        SG_DIV_GO: state_r <= SG_DIV_WAIT;
        SG_DIV_WAIT: begin
          if (div_done) begin
            term_r  <= div_q;
            state_r <= SG_SER_ACC;
          end
        end
        SG_SER_ACC: begin
          sum_r <= sum_new;
          if (n_r == 5'(SER_TERMS)) begin
            if (!phase_r) begin
              // e^-1 done, now the fractional part
              e1_r    <= e_val;
              phase_r <= 1'b1;
              term_r  <= Q52_ONE;
              sum_r   <= Q52_ONE;
              n_r     <= 5'd1;
              state_r <= SG_SER_MUL;
            end else begin
              e_r     <= e_val;
              k_r     <= t_r[15:8];
              state_r <= (t_r[15:8] == 8'd0) ? SG_FIN_GO : SG_POW_MUL;
            end
          end else begin
            n_r     <= n_r + 5'd1;
            state_r <= SG_SER_MUL;
          end
        end
        SG_POW_MUL: begin
          mul_r   <= e_r[31:0] * e1_r[31:0];
          state_r <= SG_POW_ADD;
        end
        SG_POW_ADD: begin
          e_r     <= pow_full[64:32];
          k_r     <= k_r - 8'd1;
          state_r <= (k_r == 8'd1) ? SG_FIN_GO : SG_POW_MUL;
        end
        SG_FIN_GO: state_r <= SG_FIN_WAIT;
        SG_FIN_WAIT: begin
          if (div_done) begin
            res_r   <= (div_q > DIV_N_W'(65535)) ? 16'hFFFF : div_q[15:0];
            done_r  <= 1'b1;
            state_r <= SG_IDLE;
          end
        end
        default: state_r <= SG_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;
endmodule

/* src/ydf_front.sv */
// Front end: counts elements and grid position, keeps the running argmax.
// Depends on ydf_pkg and ydf_in_if; emits one job per finished detection.
module ydf_front (
  input  logic            clk,
  input  logic            rst_n,
  ydf_in_if.sink          in_ch,
  input  logic [7:0]      grid_cols,
  input  logic [7:0]      grid_rows,
  input  logic [7:0]      class_count,
  input  ydf_pkg::q_stat_t q_stat,
  output logic            push,
  output ydf_pkg::job_t   job
);
  import ydf_pkg::*;

  logic [7:0]   ec_r;
  logic [7:0]   col_r;
  logic [7:0]   row_r;
  logic [1:0]   slot_r;
  logit_t [3:0] box_r;
  logit_t       obj_r;
  logit_t       best_r;
  logic [6:0]   best_idx_r;

  logic         acc;
  logic [8:0]   c_eff;
  logic [8:0]   gw_eff;
  logic [8:0]   gh_eff;
  logic [7:0]   e;
  logic [7:0]   col0;
  logic [7:0]   row0;
  logic [1:0]   slot0;
  logic         last;
  logit_t       best_nxt;
  logic [6:0]   best_idx_nxt;
  logic [2:0]   slot_inc;
  logic [8:0]   col_inc;
  logic [8:0]   row_inc;

  always_comb begin
    acc    = in_ch.valid && in_ch.ready;
    c_eff  = (class_count == 8'd0) ? 9'd1 :
             (class_count > 8'(MAX_CLASSES)) ? 9'(MAX_CLASSES) : {1'b0, class_count};
    gw_eff = (grid_cols == 8'd0) ? 9'd1 : {1'b0, grid_cols};
    gh_eff = (grid_rows == 8'd0) ? 9'd1 : {1'b0, grid_rows};
    e      = in_ch.frame_start ? 8'd0 : ec_r;
    col0   = in_ch.frame_start ? 8'd0 : col_r;
    row0   = in_ch.frame_start ? 8'd0 : row_r;
    slot0  = in_ch.frame_start ? 2'd0 : slot_r;
    last   = {1'b0, e} >= c_eff + 9'd4;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (e == 8'd5) begin
      best_nxt     = in_ch.logit;
      best_idx_nxt = 7'd0;
    end else if (e > 8'd5 && in_ch.logit > best_r) begin
      best_nxt     = in_ch.logit;
      best_idx_nxt = 7'(e - 8'd5);
    end
    slot_inc = {1'b0, slot0} + 3'd1;
    col_inc  = {1'b0, col0} + 9'd1;
    row_inc  = {1'b0, row0} + 9'd1;

    job.box      = box_r;
    job.obj      = obj_r;
    job.best     = best_nxt;
    job.best_idx = best_idx_nxt;
    job.col      = col0;
    job.row      = row0;
    job.slot     = (slot0 > 2'd2) ? 2'd2 : slot0;
    push         = acc && last;
  end

  assign in_ch.ready = !q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r       <= '0;
      col_r      <= '0;
      row_r      <= '0;
      slot_r     <= '0;
      best_idx_r <= '0;
    end else if (acc) begin
      if (e < 8'd4) box_r[e[1:0]] <= in_ch.logit;
      if (e == 8'd4) obj_r <= in_ch.logit;
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
      if (last) begin
        ec_r <= '0;
        if (slot_inc >= 3'd3) begin
          slot_r <= '0;
          if (col_inc >= gw_eff) begin
            col_r <= '0;
            row_r <= (row_inc >= gh_eff) ? 8'd0 : row_inc[7:0];
          end else begin
            col_r <= col_inc[7:0];
            row_r <= row0;
          end
        end else begin
          slot_r <= slot_inc[1:0];
          col_r  <= col0;
          row_r  <= row0;
        end
      end else begin
        ec_r   <= e + 8'd1;
        col_r  <= col0;
        row_r  <= row0;
        slot_r <= slot0;
      end
    end
  end
endmodule

/* src/ydf_queue.sv */
// Two-entry job queue between front and back.
// Depends on ydf_pkg.
module ydf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ydf_pkg::job_t    job_in,
  input  logic             pop,
  output ydf_pkg::job_t    job_out,
  output ydf_pkg::q_stat_t stat
);
  import ydf_pkg::*;

  job_t       ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  always_comb begin
    stat.full  = cnt_r == 2'd2;
    stat.empty = cnt_r == 2'd0;
    job_out    = ent_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        ent_r[wr_r] <= job_in;
        wr_r        <= ~wr_r;
      end
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* src/ydf_back.sv */
// Back end: sigmoids, threshold test, box decode and the output register.
// Depends on ydf_pkg, ydf_sig and ydf_out_if.
module ydf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ydf_pkg::job_t       job,
  output logic                pop,
  input  logic [1:0]          sel,
  input  logic [15:0]         conf_level,
  ydf_out_if.source           out_ch,
  output ydf_pkg::back_stat_t stat
);
  import ydf_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_SIG_GO, B_SIG_WAIT, B_CHECK, B_SQ_W, B_SQ_H,
    B_HALF_W, B_HALF_H, B_EDGE, B_OUT
  } b_state_t;

  b_state_t     state_r;
  job_t         job_r;
  logic [2:0]   idx_r;
  logic [15:0]  sg_r [6];
  logic [15:0]  score_r;
  logic [31:0]  sqw_r;
  logic [31:0]  sqh_r;
  logic [41:0]  hw_r;
  logic [41:0]  hh_r;
  logic [15:0]  edge_r [4];
  logic         out_valid_r;
  logic [15:0]  x_min_r, y_min_r, x_max_r, y_max_r, o_score_r;
  logic [6:0]   o_cls_r;

  logic         sig_start;
  logit_t       sig_logit;
  logic         sig_done;
  logic [15:0]  sig_res;
  logic [31:0]  score_full;
  logic signed [26:0] ax, ay;
  logic signed [49:0] cx, cy, hwx, hhx;
  logic [4:0]   shamt;

  always_comb begin
    case (idx_r)
      3'd0:    sig_logit = job_r.obj;
      3'd1:    sig_logit = job_r.best;
      3'd2:    sig_logit = job_r.box[0];
      3'd3:    sig_logit = job_r.box[1];
      3'd4:    sig_logit = job_r.box[2];
      default: sig_logit = job_r.box[3];
    endcase
    sig_start  = state_r == B_SIG_GO;
    pop        = (state_r == B_IDLE) && !q_empty;
    stat.busy  = state_r != B_IDLE;
    score_full = sg_r[0] * sg_r[1];
    ax    = $signed({3'b0, job_r.col, 16'd0}) + $signed({10'b0, sg_r[2], 1'b0})
          - 27'sd32768;
    ay    = $signed({3'b0, job_r.row, 16'd0}) + $signed({10'b0, sg_r[3], 1'b0})
          - 27'sd32768;
    shamt = 5'd19 + {3'b0, sel};
    cx    = {{23{ax[26]}}, ax} <<< shamt;
    cy    = {{23{ay[26]}}, ay} <<< shamt;
    hwx   = $signed({8'b0, hw_r});
    hhx   = $signed({8'b0, hh_r});
  end

  ydf_sig u_sig (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sig_start),
    .logit  (sig_logit),
    .done   (sig_done),
    .result (sig_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r   <= job;
            idx_r   <= 3'd0;
            state_r <= B_SIG_GO;
          end
        end
        B_SIG_GO: state_r <= B_SIG_WAIT;
        B_SIG_WAIT: begin
          if (sig_done) begin
            sg_r[idx_r] <= sig_res;
            if (idx_r == 3'd1) state_r <= B_CHECK;
            else if (idx_r == 3'd5) state_r <= B_SQ_W;
            else begin
              idx_r   <= idx_r + 3'd1;
              state_r <= B_SIG_GO;
            end
          end
        end
        B_CHECK: begin
          score_r <= score_full[31:16];
          if (sg_r[0] > conf_level && score_full[31:16] > conf_level) begin
            idx_r   <= 3'd2;
            state_r <= B_SIG_GO;
          end else begin
            state_r <= B_IDLE;
          end
        end
        B_SQ_W: begin
          sqw_r   <= sg_r[4] * sg_r[4];
          state_r <= B_SQ_H;
        end
        B_SQ_H: begin
          sqh_r   <= sg_r[5] * sg_r[5];
          state_r <= B_HALF_W;
        end
        B_HALF_W: begin
          hw_r    <= 42'({sqw_r, 1'b0} * anchor_wd(sel, job_r.slot));
          state_r <= B_HALF_H;
        end
        B_HALF_H: begin
          hh_r    <= 42'({sqh_r, 1'b0} * anchor_ht(sel, job_r.slot));
          state_r <= B_EDGE;
        end
        B_EDGE: begin
          edge_r[0] <= to_q4(cx - hwx);
          edge_r[1] <= to_q4(cy - hhx);
          edge_r[2] <= to_q4(cx + hwx);
          edge_r[3] <= to_q4(cy + hhx);
          state_r   <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            x_min_r     <= edge_r[0];
            y_min_r     <= edge_r[1];
            x_max_r     <= edge_r[2];
            y_max_r     <= edge_r[3];
            o_score_r   <= score_r;
            o_cls_r     <= job_r.best_idx;
            out_valid_r <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_min       = x_min_r;
  assign out_ch.y_min       = y_min_r;
  assign out_ch.x_max       = x_max_r;
  assign out_ch.y_max       = y_max_r;
  assign out_ch.score       = o_score_r;
  assign out_ch.class_index = o_cls_r;
endmodule

/* dv/ydf_box_checker.sv */
// Checker for the YOLO decode filter: watches the logit, result and register ports,
// predicts each decoded box and compares it with what the block delivers.
// Depends on ydf_pkg and the channel interfaces in ydf_ifs.
module ydf_box_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  ydf_in_if                              in_ch,
  ydf_out_if                             out_ch,
  input  logic                           cfg_we,
  input  logic [ydf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ydf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             boxes_pending
);
  import ydf_pkg::*;

  typedef struct {
    logic [15:0] x_min, y_min, x_max, y_max, score;
    logic [6:0]  class_index;
  } box_t;

  localparam int unsigned STRIDE_PX [3] = '{8, 16, 32};
  localparam int unsigned ANCHOR_PX [3][6] = '{'{10, 13, 16, 30, 33, 23},
                                               '{30, 61, 62, 45, 59, 119},
                                               '{116, 90, 156, 198, 373, 326}};

  box_t boxes_due[$];

  // register copies
  int unsigned scale_sel, cols_cfg, rows_cfg, classes_cfg, conf_min;
  // detection walk
  int unsigned elem_idx, col_pos, row_pos, slot_pos, best_idx;
  int          box_raw [4];
  int          obj_raw, best_raw;

  // exp(-fr/256) in Q1.52 by a 24-term series, fr in 0..256
  function automatic longint unsigned exp_series(longint unsigned fr);
    longint unsigned term, acc;
    term = 64'd1 << 52;
    acc  = term;
    for (int n = 1; n <= 24; n++) begin
      term = term * fr / (64'd256 * n);
      if (n % 2 == 1) acc -= term;
      else acc += term;
    end
    return acc;
  endfunction

  // logistic of a Q8.8 value, rounded to Q0.16 and saturated
  function automatic int unsigned logistic_q16(int v);
    longint unsigned e, e_one, d, s;
    int unsigned     t;
    t     = (v < 0) ? -v : v;
    e     = (exp_series(t % 256) + (64'd1 << 19)) >> 20;
    e_one = (exp_series(256) + (64'd1 << 19)) >> 20;
    for (int i = 0; i < t / 256; i++) e = (e * e_one + (64'd1 << 31)) >> 32;
    d = (64'd1 << 32) + e;
    if (v >= 0) s = ((64'd1 << 48) + d / 2) / d;
    else s = ((e << 16) + d / 2) / d;
    return (s > 65535) ? 65535 : int'(s);
  endfunction

  // Q32 pixels to Q12.4, round half up, clamp to 0..65535
  function automatic logic [15:0] pixel_q4(longint v);
    longint unsigned r;
    if (v <= 0) return 16'd0;
    r = (longint'(v) + (64'sd1 <<< 27)) >> 28;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic int unsigned eff_size(int unsigned g);
    return (g == 0) ? 1 : g;
  endfunction

  // Consume one logit word; queue a box when a detection closes and passes.
  task automatic take_logit(int v, bit frame_go);
    int unsigned c, e, sel, obj_q, cls_q, score_q;
    longint      st, aw, ah, sx, sy, sw, sh, cx, cy, hw, hh;
    box_t        b;
    c = (classes_cfg == 0) ? 1 : ((classes_cfg > MAX_CLASSES) ? MAX_CLASSES : classes_cfg);
    if (frame_go) begin
      elem_idx = 0; col_pos = 0; row_pos = 0; slot_pos = 0;
    end
    e = elem_idx;
    if (e < 4) box_raw[e] = v;
    else if (e == 4) obj_raw = v;
    else if (e == 5) begin
      best_raw = v; best_idx = 0;
    end else if (v > best_raw) begin
      best_raw = v; best_idx = e - 5;
    end
    if (e < 4 + c) begin
      elem_idx = e + 1;
      return;
    end
    sel     = (scale_sel > 2) ? 2 : scale_sel;
    obj_q   = logistic_q16(obj_raw);
    cls_q   = logistic_q16(best_raw);
    score_q = (longint'(obj_q) * cls_q) >> 16;
    if (obj_q > conf_min && score_q > conf_min) begin
      st = STRIDE_PX[sel];
      aw = ANCHOR_PX[sel][slot_pos * 2];
      ah = ANCHOR_PX[sel][slot_pos * 2 + 1];
      sx = logistic_q16(box_raw[0]);
      sy = logistic_q16(box_raw[1]);
      sw = logistic_q16(box_raw[2]);
      sh = logistic_q16(box_raw[3]);
      cx = (2 * sx - 32768 + longint'(col_pos) * 65536) * st * 65536;
      cy = (2 * sy - 32768 + longint'(row_pos) * 65536) * st * 65536;
      hw = sw * sw * 2 * aw;
      hh = sh * sh * 2 * ah;
      b.x_min = pixel_q4(cx - hw);
      b.y_min = pixel_q4(cy - hh);
      b.x_max = pixel_q4(cx + hw);
      b.y_max = pixel_q4(cy + hh);
      b.score = score_q[15:0];
      b.class_index = best_idx[6:0];
      boxes_due = {boxes_due, b};
    end
    elem_idx = 0;
    slot_pos++;
    if (slot_pos >= 3) begin
      slot_pos = 0;
      col_pos++;
      if (col_pos >= eff_size(cols_cfg)) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= eff_size(rows_cfg)) row_pos = 0;
      end
    end
  endtask

  task automatic check_box();
    box_t b;
    if (boxes_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("checker: unexpected result word x_min=%0d class=%0d",
                                     out_ch.x_min, out_ch.class_index);
      return;
    end
    b = boxes_due.pop_front();
    if (out_ch.x_min !== b.x_min || out_ch.y_min !== b.y_min || out_ch.x_max !== b.x_max ||
        out_ch.y_max !== b.y_max || out_ch.score !== b.score ||
        out_ch.class_index !== b.class_index) begin
      fail_count++;
      if (fail_count <= 10)
        $display("checker: box mismatch exp %0d %0d %0d %0d s%0d c%0d got %0d %0d %0d %0d s%0d c%0d",
                 b.x_min, b.y_min, b.x_max, b.y_max, b.score, b.class_index,
                 out_ch.x_min, out_ch.y_min, out_ch.x_max, out_ch.y_max, out_ch.score,
                 out_ch.class_index);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_sel = 0; cols_cfg = 80; rows_cfg = 80; classes_cfg = 80; conf_min = 16384;
      elem_idx = 0; col_pos = 0; row_pos = 0; slot_pos = 0; best_idx = 0;
      fail_count = 0;
      boxes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCALE:   scale_sel   = cfg_data[1:0];
          REG_GRID_W:  cols_cfg    = cfg_data[7:0];
          REG_GRID_H:  rows_cfg    = cfg_data[7:0];
          REG_CLASSES: classes_cfg = cfg_data[7:0];
          REG_CONF:    conf_min    = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) check_box();
      if (in_ch.valid && in_ch.ready) take_logit(int'(in_ch.logit), in_ch.frame_start);
    end
    boxes_pending = boxes_due.size();
  end

endmodule

/* dv/yolo_detection_decode_filter_test.sv */
// Testbench top for the YOLO decode filter: drives logit words and register writes
// through several settings, and gives the verdict from the checker's failure count.
// Depends on ydf_pkg, ydf_ifs, ydf_box_checker and the block itself.
module yolo_detection_decode_filter_test;
  import ydf_pkg::*;

  // A passing detection needs six sigmoids.
  // A queue of dropped detections can still be in flight once the last box is out,
  // so wait SETTLE_CYCLES before touching registers.
  localparam int SETTLE_CYCLES = 80000;
  localparam int HOLD_CYCLES   = 50000;
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ydf_in_if  in_ch();
  ydf_out_if out_ch();

  int fail_count, boxes_pending;
  int tx_idle, rx_idle;      // idle odds in percent for sender and receiver
  int words_sent;
  int classes_now;           // effective class count of the current setting
  bit hold_go, hold_done;
  int hold_left;
  longint cycles = 0;

  yolo_detection_decode_filter DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ydf_box_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .boxes_pending(boxes_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("yolo_detection_decode_filter regression: fail");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once asked, so that
  // the job queue fills and the block drops in_ch.ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic put_word(input logit_t v, input bit frame_go);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.logit       <= v;
    in_ch.frame_start <= frame_go;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Drain, let queued dropped detections finish, then load a new setting.
  task automatic load_setting(input int scale, input int cols, input int rows,
                              input int classes, input int conf);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (boxes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SCALE, scale);
    write_reg(REG_GRID_W, cols);
    write_reg(REG_GRID_H, rows);
    write_reg(REG_CLASSES, classes);
    write_reg(REG_CONF, conf);
    cfg_we <= 1'b0;
    classes_now = (classes == 0) ? 1 : ((classes > MAX_CLASSES) ? MAX_CLASSES : classes);
  endtask

  function automatic logit_t pick(input int lo, input int hi);
    return logit_t'($urandom_range(hi - lo) + lo);
  endfunction

  // Send one detection word for word; classes of the current setting.
  task automatic send_detection(input bit frame_go);
    logit_t tie_val;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(9) < 3) put_word(logit_t'($urandom), frame_go && i == 0);
      else put_word(pick(-1024, 1024), frame_go && i == 0);
    end
    // objectness leans positive so that most detections pass
    put_word(($urandom_range(9) == 0) ? logit_t'($urandom) : pick(-512, 2048), 1'b0);
    tie_val = pick(-1024, 2048);
    for (int i = 0; i < classes_now; i++) begin
      if ($urandom_range(3) == 0) put_word(tie_val, 1'b0);
      else put_word(($urandom_range(15) == 0) ? logit_t'($urandom) : pick(-1024, 2048), 1'b0);
    end
  endtask

  // Mostly whole detections with random content; some noise words and restarts.
  task automatic run_random(input int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 85) send_detection($urandom_range(9) == 0);
      else put_word(logit_t'($urandom), $urandom_range(1) == 1);
      if (words_sent > 1266) begin
        tx_idle = 0; rx_idle = 0;
      end else if (words_sent > 633) begin
        tx_idle = 45; rx_idle = 8;
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.logit       <= '0;
    in_ch.frame_start <= 1'b0;
    hold_go            = 1'b0;
    words_sent         = 0;
    tx_idle            = 8;
    rx_idle            = 45;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one cell, two classes, threshold zero.
    load_setting(0, 1, 1, 2, 0);
    // saturating box, tied classes keep the lower index
    for (int i = 0; i < 4; i++) put_word(16'sh7FFF, i == 0);
    put_word(16'sh7FFF, 1'b0);
    put_word(16'sd100, 1'b0);
    put_word(16'sd100, 1'b0);
    // box collapsed to the corner, second class wins
    for (int i = 0; i < 4; i++) put_word(-16'sd32768, 1'b0);
    put_word(16'sh7FFF, 1'b0);
    put_word(-16'sd5, 1'b0);
    put_word(16'sd300, 1'b0);
    // lowest objectness: dropped
    for (int i = 0; i < 4; i++) put_word(16'sd0, 1'b0);
    put_word(-16'sd32768, 1'b0);
    put_word(16'sh7FFF, 1'b0);
    put_word(-16'sd32768, 1'b0);
    // partial detection cut short by a frame restart, then both classes at minimum
    put_word(16'sd77, 1'b0);
    put_word(16'sd88, 1'b0);
    put_word(16'sd256, 1'b1);
    put_word(-16'sd256, 1'b0);
    put_word(16'sd512, 1'b0);
    put_word(-16'sd512, 1'b0);
    put_word(16'sd1000, 1'b0);
    put_word(-16'sd32768, 1'b0);
    put_word(-16'sd32768, 1'b0);

    // Scale code three, zero sizes, top threshold: nothing can pass.
    load_setting(3, 0, 0, 0, 16'hFFFF);
    run_random(30);
    // Largest grid, class count above the limit.
    load_setting(1, 255, 255, 200, 100);
    run_random(140);
    // Small grid; hold the receiver off long enough to back up the input.
    load_setting(0, 3, 2, 3, 16384);
    hold_go = 1'b1;
    run_random(450);
    load_setting(2, 2, 255, 1, 30000);
    run_random(450);
    load_setting(1, 5, 4, 4, 8000);
    run_random(450);
    load_setting(2, 255, 1, 128, 12000);
    run_random(350);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (boxes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("yolo_detection_decode_filter regression: pass");
    else $display("yolo_detection_decode_filter regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ydf_pkg.sv
src/ydf_ifs.sv
src/ydf_div.sv
src/ydf_sig.sv
src/ydf_front.sv
src/ydf_queue.sv
src/ydf_back.sv
src/yolo_detection_decode_filter.sv
dv/ydf_box_checker.sv
dv/yolo_detection_decode_filter_test.sv
